// ===== src/cts_pkg.sv =====
// cts_pkg: shared widths, defaults and elaboration-time helpers for the cosine series block
// no dependencies; imported by the channel interfaces and every module of the block

package cts_pkg;

    // default configuration
    localparam int DEF_SERIES_TERMS  = 8;
    localparam int DEF_FRACTION_BITS = 28;

    // field and datapath widths
    localparam int ANGLE_W  = 31;
    localparam int COSINE_W = 32;
    localparam int ACC_W    = 64;
    localparam int MAG_W    = 63;
    localparam int SQ_TOP   = 61;
    localparam int CHUNK_W  = 32;

    // clamp bound of every intermediate product and sum
    localparam logic [ACC_W-1:0] ACC_LIMIT = 64'h4000_0000_0000_0000;

    // n! with the running value clamped to the accumulator bound
    function automatic logic [ACC_W-1:0] cts_factorial(input int n);
        logic [2*ACC_W-1:0] prod;
        logic [ACC_W-1:0]   fact;
        fact = ACC_W'(1);
        for (int i = 1; i <= n; i++)
        begin
            prod = (2*ACC_W)'(fact) * (2*ACC_W)'(i);
            if (prod > (2*ACC_W)'(ACC_LIMIT))
            begin
                fact = ACC_LIMIT;
            end
            else
            begin
                fact = prod[ACC_W-1:0];
            end
        end
        return fact;
    endfunction

    // round the doubled quotient half up and apply the alternating sign
    function automatic logic signed [ACC_W-1:0] cts_signed_coeff(
        input logic [ACC_W-1:0] quot,
        input int               k
    );
        logic [ACC_W-1:0] mag;
        mag = (quot + ACC_W'(1)) >> 1;
        return k[0] ? -$signed(mag) : $signed(mag);
    endfunction

endpackage

// ===== src/cts_if.sv =====
// cts_if: valid/ready channels carrying the angle item and the cosine item
// depends on cts_pkg for the field widths

interface cts_angle_if import cts_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [ANGLE_W-1:0] angle;

    modport source (output valid, output angle, input ready);
    modport sink   (input valid, input angle, output ready);
endinterface

interface cts_cosine_if import cts_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [COSINE_W-1:0] cosine;

    modport source (output valid, output cosine, input ready);
    modport sink   (input valid, input cosine, output ready);
endinterface

// ===== src/cts_square.sv =====
// cts_square: front end of the chain, takes |x| and forms x squared rounded to the fraction grid
// depends on cts_pkg; two register stages, all moving on the shared advance strobe

module cts_square import cts_pkg::*; #(
    parameter int  FRACTION_BITS = DEF_FRACTION_BITS,
    localparam int X2_W          = SQ_TOP - FRACTION_BITS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      advance,
    input  logic                      angle_valid,
    input  logic signed [ANGLE_W-1:0] angle,
    output logic                      sq_valid,
    output logic [X2_W-1:0]           sq_x2
);

    localparam int SQ_W = 2 * ANGLE_W;
    localparam logic [ACC_W-1:0] X2_MAX_WIDE =
        ((ACC_W'(1) << (2 * (ANGLE_W - 1))) + (ACC_W'(1) << (FRACTION_BITS - 1)))
        >> FRACTION_BITS;
    localparam logic [X2_W-1:0] X2_MAX = X2_MAX_WIDE[X2_W-1:0];

    logic               va_reg;
    logic               vb_reg;
    logic [ANGLE_W-1:0] mag_reg;
    logic [ANGLE_W-1:0] mag_next;
    logic [X2_W-1:0]    x2_reg;
    logic [X2_W-1:0]    x2_next;
    logic [ANGLE_W:0]   angle_ext;
    logic [ANGLE_W:0]   angle_abs;
    logic [SQ_W-1:0]    sq_rounded;

    // magnitude of the angle, one bit wider so that -4 folds to +4
    always_comb
    begin
        angle_ext = {angle[ANGLE_W-1], angle};
        angle_abs = angle_ext[ANGLE_W] ? -angle_ext : angle_ext;
        mag_next  = angle_abs[ANGLE_W-1:0];
    end

    // exact square, half-up rounding, drop the extra fraction bits
    always_comb
    begin
        sq_rounded = {{ANGLE_W{1'b0}}, mag_reg} * {{ANGLE_W{1'b0}}, mag_reg}
                   + (SQ_W'(1) << (FRACTION_BITS - 1));
        x2_next    = sq_rounded[SQ_TOP-1:FRACTION_BITS];
    end

    // stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else if (advance)
        begin
            va_reg <= angle_valid;
            vb_reg <= va_reg;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            mag_reg <= mag_next;
            x2_reg  <= x2_next;
        end
    end

    assign sq_valid = vb_reg;
    assign sq_x2    = x2_reg;

    // the rounded square never exceeds the square of the largest magnitude
    a_x2_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && va_reg) |=> (vb_reg && x2_reg <= X2_MAX))
        else $error("x squared above its bound");

endmodule

// ===== src/cts_cell.sv =====
// cts_cell: one Horner step y' = c + y * x^2 as a three-stage slice of the chain
// depends on cts_pkg; coefficient fixed at elaboration from the cell's series index

module cts_cell import cts_pkg::*; #(
    parameter int  FRACTION_BITS = DEF_FRACTION_BITS,
    parameter int  K_INDEX       = 0,
    localparam int X2_W          = SQ_TOP - FRACTION_BITS
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    advance,
    input  logic                    feed_valid,
    input  logic signed [ACC_W-1:0] feed_y,
    input  logic [X2_W-1:0]         feed_x2,
    output logic                    sum_valid,
    output logic signed [ACC_W-1:0] sum_y,
    output logic [X2_W-1:0]         sum_x2
);

    // partial product split of the magnitude and of x squared
    localparam int NA   = (MAG_W + CHUNK_W - 1) / CHUNK_W;
    localparam int NB   = (X2_W + CHUNK_W - 1) / CHUNK_W;
    localparam int A_PW = NA * CHUNK_W;
    localparam int B_PW = NB * CHUNK_W;
    localparam int PW   = A_PW + B_PW;
    localparam int NPP  = NA * NB;

    // coefficient (-1)^k / (2k)! on the fraction grid
    localparam logic [ACC_W-1:0] FACT  = cts_factorial(2 * K_INDEX);
    localparam logic [ACC_W-1:0] QUOT  = (ACC_W'(1) << (FRACTION_BITS + 1)) / FACT;
    localparam logic signed [ACC_W-1:0] COEFF = cts_signed_coeff(QUOT, K_INDEX);

    localparam logic signed [ACC_W-1:0] POS_LIMIT = $signed(ACC_LIMIT);
    localparam logic signed [ACC_W-1:0] NEG_LIMIT = -$signed(ACC_LIMIT);

    logic                    v1_reg;
    logic                    v2_reg;
    logic                    v3_reg;
    logic                    neg1_reg;
    logic                    neg2_reg;
    logic [X2_W-1:0]         x2_1_reg;
    logic [X2_W-1:0]         x2_2_reg;
    logic [X2_W-1:0]         x2_3_reg;
    logic [ACC_W-1:0]        y_abs;
    logic [A_PW-1:0]         a_pad;
    logic [B_PW-1:0]         b_pad;
    logic [2*CHUNK_W-1:0]    pp_next [NPP];
    logic [2*CHUNK_W-1:0]    pp_reg  [NPP];
    logic [PW-1:0]           acc;
    logic [PW-1:0]           quo;
    logic [MAG_W-1:0]        r_next;
    logic [MAG_W-1:0]        r_reg;
    logic signed [ACC_W-1:0] term;
    logic signed [ACC_W-1:0] total;
    logic signed [ACC_W-1:0] y_next;
    logic signed [ACC_W-1:0] y_reg;

    // stage 1: sign and magnitude of y, chunked partial products with x squared
    always_comb
    begin
        y_abs = feed_y[ACC_W-1] ? ACC_W'(-feed_y) : ACC_W'(feed_y);
        a_pad = A_PW'(y_abs[MAG_W-1:0]);
        b_pad = B_PW'(feed_x2);
        for (int i = 0; i < NA; i++)
        begin
            for (int j = 0; j < NB; j++)
            begin
                pp_next[i*NB+j] = {CHUNK_W'(0), a_pad[i*CHUNK_W +: CHUNK_W]}
                                * {CHUNK_W'(0), b_pad[j*CHUNK_W +: CHUNK_W]};
            end
        end
    end

    // stage 2: gather partial products, round half up, rescale and clamp
    always_comb
    begin
        acc = PW'(1) << (FRACTION_BITS - 1);
        for (int i = 0; i < NA; i++)
        begin
            for (int j = 0; j < NB; j++)
            begin
                acc = acc + (PW'(pp_reg[i*NB+j]) << (CHUNK_W * (i + j)));
            end
        end
        quo    = acc >> FRACTION_BITS;
        r_next = (quo > PW'(ACC_LIMIT)) ? ACC_LIMIT[MAG_W-1:0] : quo[MAG_W-1:0];
    end

    // stage 3: restore the sign, add the coefficient, clamp the sum
    always_comb
    begin
        term  = neg2_reg ? -$signed({1'b0, r_reg}) : $signed({1'b0, r_reg});
        total = term + COEFF;
        if (total > POS_LIMIT)
        begin
            y_next = POS_LIMIT;
        end
        else if (total < NEG_LIMIT)
        begin
            y_next = NEG_LIMIT;
        end
        else
        begin
            y_next = total;
        end
    end

    // stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= feed_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            neg1_reg <= feed_y[ACC_W-1];
            x2_1_reg <= feed_x2;
            pp_reg   <= pp_next;
            neg2_reg <= neg1_reg;
            x2_2_reg <= x2_1_reg;
            r_reg    <= r_next;
            x2_3_reg <= x2_2_reg;
            y_reg    <= y_next;
        end
    end

    assign sum_valid = v3_reg;
    assign sum_y     = y_reg;
    assign sum_x2    = x2_3_reg;

    // a zero square gives a zero product whatever y was
    a_zero_product: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && v1_reg && x2_1_reg == '0) |=> (v2_reg && r_reg == '0))
        else $error("non-zero product from zero x squared");

    // the value handed on always lies inside the clamp bounds
    a_sum_range: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && v2_reg) |=> (v3_reg && y_reg <= POS_LIMIT && y_reg >= NEG_LIMIT))
        else $error("cell sum outside clamp bounds");

endmodule

// ===== src/cosine_taylor_series.sv =====
// cosine_taylor_series: top level, squaring front end, chain of Horner cells, saturating output
// depends on cts_pkg, cts_if, cts_square and cts_cell
//
// Takes one angle per item (signed, FRACTION_BITS fraction bits) and returns the cosine
// series truncated after SERIES_TERMS even powers, saturated to 32 bits. The datapath is
// fully pipelined: a new item is taken in every cycle while the result side keeps up, and
// each result passes through the two squaring stages, three stages per Horner cell
// (partial products, rescale and clamp, coefficient add) and the output register.
// When a result waits at the output the whole pipeline holds, so no item is lost or
// reordered; ready follows the output register and does not depend on the angle side.

module cosine_taylor_series import cts_pkg::*; #(
    parameter int SERIES_TERMS  = DEF_SERIES_TERMS,
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
    input logic          clk,
    input logic          rst_n,
    cts_angle_if.sink    angle_ch,
    cts_cosine_if.source cosine_ch
);

    localparam int CELLS = SERIES_TERMS - 1;
    localparam int X2_W  = SQ_TOP - FRACTION_BITS;

    // highest coefficient seeds the Horner recurrence
    localparam int TOP_K = SERIES_TERMS - 1;
    localparam logic [ACC_W-1:0] SEED_FACT = cts_factorial(2 * TOP_K);
    localparam logic [ACC_W-1:0] SEED_QUOT = (ACC_W'(1) << (FRACTION_BITS + 1)) / SEED_FACT;
    localparam logic signed [ACC_W-1:0] SEED = cts_signed_coeff(SEED_QUOT, TOP_K);

    localparam logic signed [ACC_W-1:0] COS_MAX = (ACC_W'(1) << (COSINE_W - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] COS_MIN = -$signed(ACC_W'(1) << (COSINE_W - 1));

    logic                       advance;
    logic                       link_valid [CELLS+1];
    logic signed [ACC_W-1:0]    link_y     [CELLS+1];
    logic [X2_W-1:0]            link_x2    [CELLS+1];
    logic                       out_valid_reg;
    logic signed [COSINE_W-1:0] cosine_reg;
    logic signed [COSINE_W-1:0] cosine_next;

    // the pipeline moves whenever the output register is free or being emptied
    assign advance        = !out_valid_reg || cosine_ch.ready;
    assign angle_ch.ready = advance;

    // squaring front end
    cts_square #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_square (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .angle_valid (angle_ch.valid),
        .angle       (angle_ch.angle),
        .sq_valid    (link_valid[0]),
        .sq_x2       (link_x2[0])
    );

    assign link_y[0] = SEED;

    // one cell per remaining coefficient, highest index first
    for (genvar g = 0; g < CELLS; g++)
    begin : g_cell
        cts_cell #(
            .FRACTION_BITS (FRACTION_BITS),
            .K_INDEX       (SERIES_TERMS - 2 - g)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .advance    (advance),
            .feed_valid (link_valid[g]),
            .feed_y     (link_y[g]),
            .feed_x2    (link_x2[g]),
            .sum_valid  (link_valid[g+1]),
            .sum_y      (link_y[g+1]),
            .sum_x2     (link_x2[g+1])
        );
    end

    // saturate to the output range
    always_comb
    begin
        if (link_y[CELLS] > COS_MAX)
        begin
            cosine_next = COS_MAX[COSINE_W-1:0];
        end
        else if (link_y[CELLS] < COS_MIN)
        begin
            cosine_next = COS_MIN[COSINE_W-1:0];
        end
        else
        begin
            cosine_next = link_y[CELLS][COSINE_W-1:0];
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= link_valid[CELLS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            cosine_reg <= cosine_next;
        end
    end

    assign cosine_ch.valid  = out_valid_reg;
    assign cosine_ch.cosine = cosine_reg;

    // no angle is taken while a finished item is held at the output
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (cosine_ch.valid && !cosine_ch.ready) |-> !angle_ch.ready)
        else $error("angle taken while the output is stalled");

endmodule
